### hdl/drd_pkg.sv
// Package for the detection row decoder: state type, register indexes, widths.
// No dependencies.
`default_nettype none
package drd_pkg;
   localparam int ValueWidth = 32;
   localparam int CoordWidth = 14;
   localparam int ClassWidth = 7;
   localparam int ScoreOutWidth = 31;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 64;
   localparam int MaxRowCount = 255;
   localparam int FracBits = 16;
   // a positive unpadded corner stays below 2^33 before the fraction shift
   localparam int DivNumWidth = 33 + FracBits;

   localparam logic [CsrIndexWidth-1:0] RegScoreThreshold = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegScale = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegPadLeft = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegPadTop = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegImageWidth = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegImageHeight = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegMaskLow = 3'd6;
   localparam logic [CsrIndexWidth-1:0] RegMaskHigh = 3'd7;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // request to the shared divider
   typedef struct packed {
      logic                   start;
      logic [DivNumWidth-1:0] numerator;
      logic [22:0]            denominator;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [39:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

### hdl/detection_row_decode_top.sv
// Top level of the detection row decoder: row capture, argmax, corner mapping.
// Depends on drd_pkg and drd_divider.
`default_nettype none
// Row values are taken one per cycle while a row streams in; the running argmax
// costs one compare per value. On a row's last value the block stops taking
// requests and, unless the row is dropped by length, class, mask or score,
// maps the four corners one after another through a single bit-serial divider;
// a corner that clips needs no division. The result sits in an output register
// until taken; a row end that finds the register still occupied waits for it
// before taking requests again.
module detection_row_decode_top #(
   parameter int MAX_CLASSES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_value,
   input  wire logic        req_last_of_row,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [13:0]      rsp_box_x,
   output logic [13:0]      rsp_box_y,
   output logic [13:0]      rsp_box_w,
   output logic [13:0]      rsp_box_h,
   output logic [6:0]       rsp_class_index,
   output logic [30:0]      rsp_score_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   localparam logic [7:0] LastClassCount = 8'(MAX_CLASSES + 4);
   localparam logic signed [33:0] HalfOne = 34'sd1 <<< (drd_pkg::FracBits - 1);

   // configuration
   logic [16:0] thr_ff;
   logic [20:0] scale_ff;
   logic [13:0] padl_ff, padt_ff, imw_ff, imh_ff;
   logic [63:0] mlo_ff, mhi_ff;

   // row state
   logic signed [31:0] coord_ff [4];
   logic signed [31:0] sixth_ff, best_ff;
   logic signed [31:0] best_first_ff;
   logic [6:0]  bcls_ff;
   logic [7:0]  count_ff;

   // end-of-row working registers
   logic signed [34:0] corner_ff [4];
   logic signed [33:0] cls_ff;
   logic signed [31:0] score_ff;
   logic [39:0] mapped_ff [4];
   logic [1:0]  sel_ff, sel_in;
   drd_pkg::state_type state_ff, state_in;

   logic        out_valid_ff, out_valid_in;
   logic [13:0] ox_ff, oy_ff, ow_ff, oh_ff;
   logic [6:0]  ocls_ff;
   logic [30:0] oscore_ff;

   drd_pkg::div_req_type div_req;
   drd_pkg::div_rsp_type div_rsp;

   drd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic accept_req;
   assign req_stall  = (state_ff != drd_pkg::ST_ACCEPT);
   assign accept_req = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 17'd16384;
         scale_ff <= 21'd65536;
         padl_ff  <= '0;
         padt_ff  <= '0;
         imw_ff   <= 14'd640;
         imh_ff   <= 14'd640;
         mlo_ff   <= '1;
         mhi_ff   <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            drd_pkg::RegScoreThreshold: thr_ff   <= csr_data[16:0];
            drd_pkg::RegScale:          scale_ff <= csr_data[20:0];
            drd_pkg::RegPadLeft:        padl_ff  <= csr_data[13:0];
            drd_pkg::RegPadTop:         padt_ff  <= csr_data[13:0];
            drd_pkg::RegImageWidth:     imw_ff   <= csr_data[13:0];
            drd_pkg::RegImageHeight:    imh_ff   <= csr_data[13:0];
            drd_pkg::RegMaskLow:        mlo_ff   <= csr_data;
            drd_pkg::RegMaskHigh:       mhi_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // sixth-value class rounding, half away from zero
   logic signed [33:0] sv_ext, sv_abs, sv_rnd;
   always_comb begin
      sv_ext = 34'(sixth_ff);
      sv_abs = sv_ext[33] ? -sv_ext : sv_ext;
      sv_rnd = (sv_abs + HalfOne) >>> drd_pkg::FracBits;
   end

   // row capture and argmax
   logic [7:0] cnt_next;
   assign cnt_next = (count_ff == 8'(drd_pkg::MaxRowCount)) ? count_ff : count_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset || (state_ff == drd_pkg::ST_CHECK)) begin
         coord_ff[0] <= '0;
         coord_ff[1] <= '0;
         coord_ff[2] <= '0;
         coord_ff[3] <= '0;
         sixth_ff    <= '0;
         best_ff     <= '0;
         bcls_ff     <= '0;
         count_ff    <= '0;
      end else if (accept_req) begin
         count_ff <= cnt_next;
         if (count_ff < 8'd4) begin
            coord_ff[count_ff[1:0]] <= req_value;
         end else if (count_ff < LastClassCount) begin
            if (count_ff == 8'd4) begin
               best_ff <= req_value;
               bcls_ff <= '0;
            end else begin
               if (count_ff == 8'd5) sixth_ff <= req_value;
               if (req_value > best_ff) begin
                  best_ff <= req_value;
                  bcls_ff <= 7'(count_ff - 8'd4);
               end
            end
         end
      end
   end

   // corner forms at row end
   logic signed [34:0] c0, c1, c2, c3;
   logic row_done;
   assign c0 = 35'(coord_ff[0]);
   assign c1 = 35'(coord_ff[1]);
   assign c2 = 35'(coord_ff[2]);
   assign c3 = 35'(coord_ff[3]);
   assign row_done = (state_ff == drd_pkg::ST_CHECK);

   logic short_row, six_row;
   assign short_row = count_ff < 8'd6;
   assign six_row   = count_ff == 8'd6;

   always_ff @(posedge clock) begin
      if (row_done) begin
         if (six_row) begin
            corner_ff[0] <= c0 <<< 1;
            corner_ff[1] <= c1 <<< 1;
            corner_ff[2] <= c2 <<< 1;
            corner_ff[3] <= c3 <<< 1;
            cls_ff   <= sixth_ff[31] ? -sv_rnd : sv_rnd;
            score_ff <= best_first_ff;
         end else begin
            corner_ff[0] <= (c0 <<< 1) - c2;
            corner_ff[1] <= (c1 <<< 1) - c3;
            corner_ff[2] <= (c0 <<< 1) + c2;
            corner_ff[3] <= (c1 <<< 1) + c3;
            cls_ff   <= 34'(bcls_ff);
            score_ff <= best_ff;
         end
      end
   end

   // the fifth value is the first argmax entry; keep it apart for six-value rows
   always_ff @(posedge clock) begin
      if (reset || row_done) best_first_ff <= '0;
      else if (accept_req && count_ff == 8'd4) best_first_ff <= req_value;
   end

   // class, mask and score filter
   logic cls_ok, mask_bit, score_ok;
   always_comb begin
      cls_ok   = !cls_ff[33] && (cls_ff < 34'(MAX_CLASSES));
      mask_bit = cls_ff[6] ? mhi_ff[cls_ff[5:0]] : mlo_ff[cls_ff[5:0]];
      score_ok = !score_ff[31] && (33'(score_ff) >= 33'(thr_ff));
   end

   // corner mapping for the selected corner
   logic [20:0] scale_eff;
   logic [22:0] den;
   logic [13:0] pad_sel, lim_sel;
   logic signed [36:0] num;
   logic [37:0] lim_prod;
   logic        num_le0, num_ge;
   assign scale_eff = (scale_ff == '0) ? 21'd1 : scale_ff;
   assign den       = {1'b0, scale_eff, 1'b0};
   assign pad_sel   = sel_ff[0] ? padt_ff : padl_ff;
   assign lim_sel   = sel_ff[0] ? imh_ff : imw_ff;
   assign num       = 37'(corner_ff[sel_ff]) - (37'(pad_sel) <<< (drd_pkg::FracBits + 1));
   assign lim_prod  = 38'(lim_sel) * 38'(den);
   assign num_le0   = num[36] || (num == '0);
   assign num_ge    = !num_le0 && (38'(num) >= lim_prod);

   // a numerator that reaches the divider is positive and below 2^33
   logic [drd_pkg::DivNumWidth-1:0] div_num;
   assign div_num = {num[32:0], {drd_pkg::FracBits{1'b0}}};

   always_comb begin
      div_req.start       = (state_ff == drd_pkg::ST_DIV_START) && !num_le0 && !num_ge;
      div_req.numerator   = div_num;
      div_req.denominator = den;
   end

   always_ff @(posedge clock) begin
      if (state_ff == drd_pkg::ST_DIV_START) begin
         if (num_le0) mapped_ff[sel_ff] <= '0;
         else if (num_ge) mapped_ff[sel_ff] <= 40'(lim_sel) << drd_pkg::FracBits;
      end else if (state_ff == drd_pkg::ST_DIV_RUN && div_rsp.done) begin
         mapped_ff[sel_ff] <= div_rsp.quotient;
      end
   end

   // final rounding
   logic signed [40:0] dw, dh;
   logic [40:0] wr, hr, xr, yr;
   logic box_ok;
   always_comb begin
      dw = 41'(mapped_ff[2]) - 41'(mapped_ff[0]);
      dh = 41'(mapped_ff[3]) - 41'(mapped_ff[1]);
      wr = 41'(dw + 41'(HalfOne)) >> drd_pkg::FracBits;
      hr = 41'(dh + 41'(HalfOne)) >> drd_pkg::FracBits;
      xr = (41'(mapped_ff[0]) + 41'(HalfOne)) >> drd_pkg::FracBits;
      yr = (41'(mapped_ff[1]) + 41'(HalfOne)) >> drd_pkg::FracBits;
      box_ok = !dw[40] && (dw != '0) && !dh[40] && (dh != '0) && (wr != '0) && (hr != '0);
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         drd_pkg::ST_ACCEPT: begin
            if (accept_req && req_last_of_row) state_in = drd_pkg::ST_CHECK;
         end
         drd_pkg::ST_CHECK: begin
            state_in = short_row ? drd_pkg::ST_ACCEPT : drd_pkg::ST_FINISH;
            sel_in   = 2'd0;
         end
         drd_pkg::ST_FINISH: begin
            // drop the row here when class, mask or score rule it out
            if (!(cls_ok && mask_bit && score_ok)) state_in = drd_pkg::ST_ACCEPT;
            else state_in = drd_pkg::ST_DIV_START;
         end
         drd_pkg::ST_DIV_START: begin
            if (div_req.start) state_in = drd_pkg::ST_DIV_RUN;
            else if (sel_ff == 2'd3) state_in = drd_pkg::ST_OUTPUT;
            else sel_in = sel_ff + 2'd1;
         end
         drd_pkg::ST_DIV_RUN: begin
            if (div_rsp.done) begin
               if (sel_ff == 2'd3) state_in = drd_pkg::ST_OUTPUT;
               else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = drd_pkg::ST_DIV_START;
               end
            end
         end
         drd_pkg::ST_OUTPUT: begin
            if (!out_valid_ff || !rsp_stall) state_in = drd_pkg::ST_ACCEPT;
         end
         default: state_in = drd_pkg::ST_ACCEPT;
      endcase
   end

   // sequencer: outputs
   logic load_out;
   always_comb begin
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && rsp_stall;
      unique case (state_ff)
         drd_pkg::ST_OUTPUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               load_out     = box_ok;
               out_valid_in = box_ok;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drd_pkg::ST_ACCEPT;
         sel_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
      if (load_out) begin
         ox_ff     <= xr[13:0];
         oy_ff     <= yr[13:0];
         ow_ff     <= wr[13:0];
         oh_ff     <= hr[13:0];
         ocls_ff   <= cls_ff[6:0];
         oscore_ff <= score_ff[30:0];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_box_x       = ox_ff;
   assign rsp_box_y       = oy_ff;
   assign rsp_box_w       = ow_ff;
   assign rsp_box_h       = oh_ff;
   assign rsp_class_index = ocls_ff;
   assign rsp_score_out   = oscore_ff;
endmodule
`default_nettype wire

### hdl/drd_divider.sv
// Restoring divider, one quotient bit per cycle, DivNumWidth by 23 bits unsigned.
// Depends on drd_pkg.
`default_nettype none
module drd_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire drd_pkg::div_req_type div_req,
   output drd_pkg::div_rsp_type   div_rsp
);
   logic [drd_pkg::DivNumWidth-1:0] quot_ff, quot_in;
   logic [23:0] rem_ff, rem_in;
   logic [22:0] den_ff, den_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [24:0] trial;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quot_ff[drd_pkg::DivNumWidth-1]} - {2'b00, den_ff};
      if (div_req.start) begin
         quot_in  = div_req.numerator;
         rem_in   = '0;
         den_in   = div_req.denominator;
         count_in = 6'(drd_pkg::DivNumWidth);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[24]) begin
            rem_in  = trial[23:0];
            quot_in = {quot_ff[drd_pkg::DivNumWidth-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[22:0], quot_ff[drd_pkg::DivNumWidth-1]};
            quot_in = {quot_ff[drd_pkg::DivNumWidth-2:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   // the quotient never exceeds the clip limit, so 40 bits carry it
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff[39:0];
endmodule
`default_nettype wire
